// File: src/mzc_pkg.sv
// Shared widths, codes and stage types of the m/z calibration pipeline.
`default_nettype none
package mzc_pkg;

  localparam int unsigned MZ_W    = 48;
  localparam int unsigned ROOT_W  = 49;
  localparam int unsigned REM_W   = 52;
  localparam int unsigned T_W     = 50;
  localparam int unsigned MUL_W   = 50;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned DEN_W   = 97;
  localparam int unsigned QUO_W   = 48;
  localparam int unsigned NUM_W   = QUO_W + DEN_W + 1;
  localparam int unsigned ROOT_PAD = 2 * ROOT_W - MZ_W;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_FTICR  = 2'd1;
  localparam logic [1:0] MODE_LINEAR = 2'd2;
  localparam logic [1:0] MODE_TOF    = 2'd3;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_COEF_A = 2'd1;
  localparam logic [1:0] REG_COEF_B = 2'd2;

  localparam logic [MZ_W-1:0]  MZ_MAX    = {MZ_W{1'b1}};
  localparam logic [DEN_W-1:0] ONE_Q79   = DEN_W'(1) << 79;
  localparam logic [DEN_W-1:0] ONE_Q43   = DEN_W'(1) << 43;
  localparam logic [MZ_W-1:0]  COEF_A_RST = MZ_W'(1) << 43;

  typedef struct packed {
    logic [MZ_W-1:0]   p;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } root_stage_t;

  typedef struct packed {
    logic              forced;
    logic [MZ_W-1:0]   f_mz;
    logic              f_err;
    logic [DEN_W-1:0]  den;
    logic [NUM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
  } div_stage_t;

endpackage
`default_nettype wire

// File: src/mz_calibration_apply.sv
// Top level: m/z recalibration pipeline with configuration registers.
//
// Recalibrates one peak m/z per clock under the FTICR inverse, linear or
// TOF square-root law. A peak passes an input register, 49 square-root
// cells, a root offset stage, a two-stage multiplier pair, an operand
// stage, an overflow check, 48 divider cells and the output register;
// one peak accepted every cycle while the skid register is empty.
// A skid register behind the output keeps the pipeline moving while a
// result waits; peak_ready_o drops only while that skid register is full.
`default_nettype none
module mz_calibration_apply
  import mzc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_addr_i,
  input  wire logic [MZ_W-1:0]  cfg_wdata_i,
  input  wire logic             peak_valid_i,
  output logic                  peak_ready_o,
  input  wire logic [MZ_W-1:0]  peak_mz_i,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output logic [MZ_W-1:0]       recal_mz_o,
  output logic                  range_error_o
);

  localparam int unsigned ROOT_CELLS = ROOT_W;
  localparam int unsigned DIV_CELLS  = QUO_W;

  logic [1:0]      mode_q;
  logic [MZ_W-1:0] coef_a_q, coef_b_q;
  logic            a_neg, b_neg;
  logic [MZ_W-1:0] am, bm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_FTICR;
      coef_a_q <= COEF_A_RST;
      coef_b_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MODE:   mode_q   <= cfg_wdata_i[1:0];
        REG_COEF_A: coef_a_q <= cfg_wdata_i;
        REG_COEF_B: coef_b_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign a_neg = coef_a_q[MZ_W-1];
  assign b_neg = coef_b_q[MZ_W-1];
  assign am    = a_neg ? (~coef_a_q + MZ_W'(1)) : coef_a_q;
  assign bm    = b_neg ? (~coef_b_q + MZ_W'(1)) : coef_b_q;

  logic en;
  logic sk_valid_q;
  assign en           = !sk_valid_q;
  assign peak_ready_o = en;

  logic            v_in_q;
  logic [MZ_W-1:0] p_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q <= 1'b0;
    end else if (en) begin
      v_in_q <= peak_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_in_q <= peak_mz_i;
    end
  end

  logic [ROOT_CELLS:0] rv;
  root_stage_t         rs [ROOT_CELLS+1];

  assign rv[0] = v_in_q;
  always_comb begin
    rs[0]      = '0;
    rs[0].p    = p_in_q;
  end

  for (genvar j = 0; j < ROOT_CELLS; j++) begin : g_root
    mzc_root_cell #(.PAIR(ROOT_CELLS - 1 - j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (rv[j]),
      .stage_i (rs[j]),
      .valid_o (rv[j+1]),
      .stage_o (rs[j+1])
    );
  end

  logic [ROOT_W-1:0] s;
  logic [T_W-1:0]    t_d, t_q;
  logic [MZ_W-1:0]   p_t_q;
  logic              v_t_q;

  assign s = rs[ROOT_CELLS].root;

  always_comb begin
    if (b_neg) begin
      t_d = T_W'(s) + T_W'(bm);
    end else if (s >= ROOT_W'(bm)) begin
      t_d = T_W'(s - ROOT_W'(bm));
    end else begin
      t_d = T_W'(ROOT_W'(bm) - s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_t_q <= 1'b0;
    end else if (en) begin
      v_t_q <= rv[ROOT_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q   <= t_d;
      p_t_q <= rs[ROOT_CELLS].p;
    end
  end

  logic [MUL_W-1:0]  xa, xb, ya, yb;
  logic [PROD_W-1:0] xp, yp;
  logic              vm1_q, vm2_q;

  always_comb begin
    if (mode_q == MODE_TOF) begin
      xa = MUL_W'(t_q);
      xb = MUL_W'(t_q);
      ya = MUL_W'(am);
      yb = MUL_W'(am);
    end else begin
      xa = MUL_W'(am);
      xb = MUL_W'(p_t_q);
      ya = MUL_W'(bm);
      yb = MUL_W'(p_t_q);
    end
  end

  mzc_mul #(.W(MUL_W)) u_mul_x (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (xa),
    .b_i   (xb),
    .p_o   (xp)
  );

  mzc_mul #(.W(MUL_W)) u_mul_y (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (ya),
    .b_i   (yb),
    .p_o   (yp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm1_q <= 1'b0;
      vm2_q <= 1'b0;
    end else if (en) begin
      vm1_q <= v_t_q;
      vm2_q <= vm1_q;
    end
  end

  div_stage_t form_d;
  logic [DEN_W-1:0] bp;
  logic             dneg, dzero, xz;

  always_comb begin
    form_d = '0;
    form_d.den = DEN_W'(1);
    bp    = yp[DEN_W-1:0];
    xz    = (xp == '0);
    dneg  = 1'b0;
    dzero = 1'b0;
    unique case (mode_q)
      MODE_FTICR: begin
        if (b_neg) begin
          form_d.den = ONE_Q79 + bp;
        end else if (bp < ONE_Q79) begin
          form_d.den = ONE_Q79 - bp;
        end else if (bp == ONE_Q79) begin
          dzero = 1'b1;
        end else begin
          form_d.den = bp - ONE_Q79;
          dneg       = 1'b1;
        end
        form_d.rem = NUM_W'({xp, 36'd0});
        if (dzero) begin
          form_d.forced = 1'b1;
          form_d.f_mz   = MZ_MAX;
          form_d.f_err  = 1'b1;
        end else if (xz) begin
          form_d.forced = 1'b1;
        end else if (a_neg != dneg) begin
          form_d.forced = 1'b1;
          form_d.f_err  = 1'b1;
        end
      end
      MODE_LINEAR: begin
        form_d.den = ONE_Q43;
        form_d.rem = NUM_W'(xp);
        if (xz) begin
          form_d.forced = 1'b1;
        end else if (a_neg) begin
          form_d.forced = 1'b1;
          form_d.f_err  = 1'b1;
        end
      end
      MODE_TOF: begin
        form_d.den = yp[DEN_W-1:0];
        form_d.rem = NUM_W'({xp, 36'd0});
        if (am == '0) begin
          form_d.forced = 1'b1;
          form_d.f_mz   = MZ_MAX;
          form_d.f_err  = 1'b1;
        end else if (xz) begin
          form_d.forced = 1'b1;
        end
      end
      default: begin
        form_d.forced = 1'b1;
        form_d.f_err  = 1'b1;
      end
    endcase
  end

  logic                 dv [DIV_CELLS+2];
  div_stage_t           ds [DIV_CELLS+2];
  div_stage_t           ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv[0] <= 1'b0;
      dv[1] <= 1'b0;
    end else if (en) begin
      dv[0] <= vm2_q;
      dv[1] <= dv[0];
    end
  end

  always_comb begin
    ov_d = ds[0];
    if (!ds[0].forced && (ds[0].rem[NUM_W-1:QUO_W] >= {1'b0, ds[0].den})) begin
      ov_d.forced = 1'b1;
      ov_d.f_mz   = MZ_MAX;
      ov_d.f_err  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ds[0] <= form_d;
      ds[1] <= ov_d;
    end
  end

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    mzc_div_cell #(.BIT(DIV_CELLS - 1 - j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[j+1]),
      .stage_i (ds[j+1]),
      .valid_o (dv[j+2]),
      .stage_o (ds[j+2])
    );
  end

  logic            last_v;
  logic [MZ_W-1:0] last_mz;
  logic            last_err;
  logic            out_valid_q, out_err_q, sk_err_q;
  logic [MZ_W-1:0] out_mz_q, sk_mz_q;

  assign last_v   = dv[DIV_CELLS+1];
  assign last_mz  = ds[DIV_CELLS+1].forced ? ds[DIV_CELLS+1].f_mz : ds[DIV_CELLS+1].quo;
  assign last_err = ds[DIV_CELLS+1].forced & ds[DIV_CELLS+1].f_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else if (en) begin
      if (last_v) begin
        if (!out_valid_q || res_ready_i) begin
          out_valid_q <= 1'b1;
        end else begin
          sk_valid_q <= 1'b1;
        end
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end else if (res_ready_i) begin
      sk_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (last_v) begin
        if (!out_valid_q || res_ready_i) begin
          out_mz_q  <= last_mz;
          out_err_q <= last_err;
        end else begin
          sk_mz_q  <= last_mz;
          sk_err_q <= last_err;
        end
      end
    end else if (res_ready_i) begin
      out_mz_q  <= sk_mz_q;
      out_err_q <= sk_err_q;
    end
  end

  assign res_valid_o   = out_valid_q;
  assign recal_mz_o    = out_mz_q;
  assign range_error_o = out_err_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> res_valid_o)
    else $error("skid register holds a result ahead of an empty output");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && last_v && res_valid_o && !res_ready_i) |=> sk_valid_q)
    else $error("result dropped while output stalled");

  a_err_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && range_error_o) |-> (recal_mz_o == '0 || recal_mz_o == MZ_MAX))
    else $error("range error without a saturated result");

endmodule
`default_nettype wire

// File: src/mzc_root_cell.sv
// One square-root cell: retires one bit of the root per stage.
`default_nettype none
module mzc_root_cell
  import mzc_pkg::*;
#(
  parameter int unsigned PAIR = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  root_stage_t      stage_i,
  output logic             valid_o,
  output root_stage_t      stage_o
);

  logic [2*ROOT_W-1:0] x;
  logic [REM_W+1:0]    tmp;
  logic [REM_W+1:0]    trial;
  logic [REM_W+1:0]    diff;
  logic                take;
  logic                valid_q;
  root_stage_t         stage_d;
  root_stage_t         stage_q;

  assign x     = {stage_i.p, ROOT_PAD'(0)};
  assign tmp   = {stage_i.rem, x[2*PAIR+1 -: 2]};
  assign trial = (REM_W+2)'({stage_i.root, 2'b01});
  assign diff  = tmp - trial;
  assign take  = (tmp >= trial);

  always_comb begin
    stage_d   = stage_i;
    if (take) begin
      stage_d.rem  = diff[REM_W-1:0];
      stage_d.root = {stage_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      stage_d.rem  = tmp[REM_W-1:0];
      stage_d.root = {stage_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire

// File: src/mzc_mul.sv
// Two-stage multiplier built from four half-width partial products.
`default_nettype none
module mzc_mul
  import mzc_pkg::*;
#(
  parameter int unsigned W = 50
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [W-1:0]   a_i,
  input  wire logic [W-1:0]   b_i,
  output logic [2*W-1:0]      p_o
);

  localparam int unsigned H = W / 2;

  logic [2*H-1:0] ll_q, lh_q, hl_q, hh_q;
  logic [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= (2*H)'(a_i[H-1:0]) * (2*H)'(b_i[H-1:0]);
      lh_q <= (2*H)'(a_i[H-1:0]) * (2*H)'(b_i[W-1:H]);
      hl_q <= (2*H)'(a_i[W-1:H]) * (2*H)'(b_i[H-1:0]);
      hh_q <= (2*H)'(a_i[W-1:H]) * (2*H)'(b_i[W-1:H]);
      p_q  <= (2*W)'(ll_q) + (((2*W)'(lh_q) + (2*W)'(hl_q)) << H)
            + ((2*W)'(hh_q) << (2*H));
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// File: src/mzc_div_cell.sv
// One divider cell: decides one quotient bit by compare and subtract.
`default_nettype none
module mzc_div_cell
  import mzc_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   en_i,
  input  wire logic   valid_i,
  input  div_stage_t  stage_i,
  output logic        valid_o,
  output div_stage_t  stage_o
);

  logic [DEN_W:0] hi;
  logic [DEN_W:0] dd;
  logic           valid_q;
  div_stage_t     stage_d;
  div_stage_t     stage_q;

  assign hi = stage_i.rem[BIT+DEN_W:BIT];
  assign dd = {1'b0, stage_i.den};

  always_comb begin
    stage_d = stage_i;
    if (hi >= dd) begin
      stage_d.rem[BIT+DEN_W:BIT] = hi - dd;
      stage_d.quo[BIT]           = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire

// File: tb/mz_calibration_apply_tb.sv
// Testbench for mz_calibration_apply: predicts each recalibrated peak and checks every result.
`timescale 1ns / 1ps
module mz_calibration_apply_tb;
  import mzc_pkg::*;

  typedef struct {
    logic [MZ_W-1:0] mz;
    logic            err;
  } recal_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_addr_i = REG_MODE;
  logic [MZ_W-1:0]  cfg_wdata_i = '0;
  logic             peak_valid_i = 1'b0;
  logic             peak_ready_o;
  logic [MZ_W-1:0]  peak_mz_i = '0;
  logic             res_valid_o;
  logic             res_ready_i = 1'b0;
  logic [MZ_W-1:0]  recal_mz_o;
  logic             range_error_o;

  logic [1:0]       law;
  logic [MZ_W-1:0]  coef_a;
  logic [MZ_W-1:0]  coef_b;
  recal_t           recal_q[$];
  int               fail_cnt = 0;
  int               hold_cycles = 0;
  bit               tx_idle_en = 1'b1;
  bit               rx_idle_en = 1'b1;

  mz_calibration_apply u_top (.*);

  always #2 clk_i = ~clk_i;

  function automatic void div48(input logic [199:0] num, input logic [199:0] den,
                                output logic [MZ_W-1:0] q, output logic ovf);
    logic [199:0] quo;
    if (num >= (den << 48)) begin
      q = MZ_MAX;
      ovf = 1'b1;
    end else begin
      quo = num / den;
      q = quo[MZ_W-1:0];
      ovf = 1'b0;
    end
  endfunction

  function automatic recal_t recalibrate(input logic [MZ_W-1:0] p);
    recal_t r;
    logic a_neg, b_neg, d_neg;
    logic [MZ_W-1:0] am, bm;
    logic [199:0] num, den, bp, k, x, sq;
    logic [48:0] s, c;
    logic [49:0] t;
    a_neg = coef_a[MZ_W-1];
    b_neg = coef_b[MZ_W-1];
    am = a_neg ? -coef_a : coef_a;
    bm = b_neg ? -coef_b : coef_b;
    r.mz = '0;
    r.err = 1'b0;
    case (law)
      MODE_FTICR: begin
        bp = 200'(bm) * 200'(p);
        k = 200'(1) << 79;
        d_neg = 1'b0;
        if (b_neg) den = k + bp;
        else if (bp < k) den = k - bp;
        else begin
          den = bp - k;
          d_neg = 1'b1;
        end
        num = 200'(am) * 200'(p);
        if (den == 0) begin
          r.mz = MZ_MAX;
          r.err = 1'b1;
        end else if (num == 0) begin
          r.mz = '0;
        end else if (a_neg != d_neg) begin
          r.err = 1'b1;
        end else begin
          div48(num << 36, den, r.mz, r.err);
        end
      end
      MODE_LINEAR: begin
        num = 200'(am) * 200'(p);
        if (num == 0) r.mz = '0;
        else if (a_neg) r.err = 1'b1;
        else div48(num, 200'(1) << 43, r.mz, r.err);
      end
      MODE_TOF: begin
        if (am == 0) begin
          r.mz = MZ_MAX;
          r.err = 1'b1;
        end else begin
          x = 200'(p) << 50;
          s = '0;
          for (int i = 48; i >= 0; i--) begin
            c = s | (49'(1) << i);
            sq = 200'(c) * 200'(c);
            if (sq <= x) s = c;
          end
          if (b_neg) t = 50'(s) + 50'(bm);
          else if (50'(s) >= 50'(bm)) t = 50'(s) - 50'(bm);
          else t = 50'(bm) - 50'(s);
          if (t != 0) begin
            num = (200'(t) * 200'(t)) << 36;
            den = 200'(am) * 200'(am);
            div48(num, den, r.mz, r.err);
          end
        end
      end
      default: r.err = 1'b1;
    endcase
    return r;
  endfunction

  task automatic send_peak(input logic [MZ_W-1:0] p);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      peak_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    peak_valid_i <= 1'b1;
    peak_mz_i <= p;
    do @(posedge clk_i); while (!peak_ready_o);
    recal_q.push_back(recalibrate(p));
  endtask

  task automatic wait_drained();
    peak_valid_i <= 1'b0;
    while (recal_q.size() != 0) @(posedge clk_i);
    repeat (110) @(posedge clk_i);
  endtask

  // write all registers back to back, then one spare index that must be ignored
  task automatic load_law(input logic [1:0] m, input logic [MZ_W-1:0] a,
                          input logic [MZ_W-1:0] b);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= REG_MODE;
    cfg_wdata_i <= MZ_W'(m);
    @(posedge clk_i);
    cfg_addr_i <= REG_COEF_A;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_addr_i <= REG_COEF_B;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_addr_i <= 2'd3;
    cfg_wdata_i <= MZ_W'({$urandom, $urandom});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    law = m;
    coef_a = a;
    coef_b = b;
    @(posedge clk_i);
  endtask

  function automatic logic [MZ_W-1:0] rand_peak();
    logic [MZ_W-1:0] v, bm;
    logic [199:0] pole;
    v = MZ_W'({$urandom, $urandom});
    bm = coef_b[MZ_W-1] ? -coef_b : coef_b;
    case ($urandom_range(0, 5))
      0: return v;
      1: return v >> $urandom_range(0, 47);
      2: return (MZ_W'(1) << 36) + MZ_W'($signed($urandom_range(0, 2000)) - 1000);
      3: return $urandom_range(0, 1) ? MZ_MAX - MZ_W'($urandom_range(0, 3))
                                     : MZ_W'($urandom_range(0, 3));
      default: begin
        if (bm == 0) return v >> $urandom_range(20, 47);
        pole = (200'(1) << 79) / 200'(bm);
        return pole[MZ_W-1:0] + MZ_W'($signed($urandom_range(0, 64)) - 32);
      end
    endcase
  endfunction

  function automatic logic [MZ_W-1:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return MZ_W'({$urandom, $urandom});
      1: return $urandom_range(0, 1) ? {1'b0, {(MZ_W-1){1'b1}}} : {1'b1, {(MZ_W-1){1'b0}}};
      2: return -(COEF_A_RST + MZ_W'($urandom_range(0, 1 << 30)));
      3: return MZ_W'($urandom) << $urandom_range(0, 16);
      default: return COEF_A_RST + MZ_W'($signed($urandom) >>> 8);
    endcase
  endfunction

  task automatic test_fticr_law();
    load_law(MODE_FTICR, COEF_A_RST, '0);
    send_peak('0);
    send_peak(MZ_MAX);
    send_peak(MZ_W'(1) << 36);
    send_peak(MZ_W'(1));
    load_law(MODE_FTICR, COEF_A_RST, COEF_A_RST);
    send_peak(MZ_W'(1) << 36);
    send_peak((MZ_W'(1) << 36) + 1);
    send_peak((MZ_W'(1) << 36) - 1);
    load_law(MODE_FTICR, -COEF_A_RST, -COEF_A_RST);
    send_peak(MZ_W'(1) << 36);
    send_peak(MZ_MAX);
  endtask

  task automatic test_linear_law();
    load_law(MODE_LINEAR, {1'b0, {(MZ_W-1){1'b1}}}, {1'b1, {(MZ_W-1){1'b0}}});
    send_peak(MZ_MAX);
    send_peak(MZ_W'(1));
    send_peak('0);
    load_law(MODE_LINEAR, {1'b1, {(MZ_W-1){1'b0}}}, '0);
    send_peak(MZ_W'(5));
    send_peak('0);
  endtask

  task automatic test_tof_law();
    load_law(MODE_TOF, '0, COEF_A_RST);
    send_peak(MZ_W'(1) << 36);
    load_law(MODE_TOF, COEF_A_RST, COEF_A_RST);
    send_peak(MZ_W'(1) << 36);
    send_peak(MZ_MAX);
    send_peak('0);
    load_law(MODE_TOF, MZ_W'(1), {1'b1, {(MZ_W-1){1'b0}}});
    send_peak(MZ_MAX);
    load_law(MODE_TOF, -COEF_A_RST, {1'b0, {(MZ_W-1){1'b1}}});
    send_peak(MZ_W'(12345));
  endtask

  task automatic test_no_law();
    load_law(MODE_NONE, COEF_A_RST, '0);
    send_peak(MZ_W'(1) << 36);
    send_peak(MZ_MAX);
  endtask

  task automatic test_random_laws(input int n_sets, input int n_peaks);
    for (int s = 0; s < n_sets; s++) begin
      load_law(($urandom_range(0, 15) == 0) ? MODE_NONE : 2'($urandom_range(1, 3)),
               rand_coef(), rand_coef());
      for (int i = 0; i < n_peaks; i++) send_peak(rand_peak());
    end
  endtask

  task automatic test_output_stall();
    load_law(MODE_LINEAR, COEF_A_RST, '0);
    tx_idle_en = 1'b0;
    hold_cycles = 300;
    for (int i = 0; i < 200; i++) send_peak(rand_peak());
    tx_idle_en = 1'b1;
  endtask

  initial begin
    law = MODE_FTICR;
    coef_a = COEF_A_RST;
    coef_b = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fticr_law();
    test_linear_law();
    test_tof_law();
    test_no_law();
    test_random_laws(12, 100);
    test_output_stall();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_laws(3, 50);
    wait_drained();
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        res_ready_i <= 1'b0;
        hold_cycles--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        res_ready_i <= 1'b0;
        repeat ($urandom_range(0, 7)) @(posedge clk_i);
      end else begin
        res_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    recal_t e;
    if (rst_ni && res_valid_o && res_ready_i) begin
      if (recal_q.size() == 0) begin
        $error("result with nothing expected: recal_mz %h", recal_mz_o);
        fail_cnt++;
      end else begin
        e = recal_q.pop_front();
        if (recal_mz_o !== e.mz) begin
          $error("recal_mz expected %h actual %h", e.mz, recal_mz_o);
          fail_cnt++;
        end
        if (range_error_o !== e.err) begin
          $error("range_error expected %b actual %b", e.err, range_error_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #4ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
src/mzc_pkg.sv
src/mzc_root_cell.sv
src/mzc_mul.sv
src/mzc_div_cell.sv
src/mz_calibration_apply.sv
tb/mz_calibration_apply_tb.sv
